// ----- sv/bbp_pkg.sv -----
// Shared types, widths and constants for the bearing pipeline.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package bbp_pkg;

   // Port field widths
   localparam int LAT_W  = 31;
   localparam int LON_W  = 32;
   localparam int BEAR_W = 25;

   // Internal widths
   localparam int ANG_W  = 34;   // binary angle, 2^32 units per turn, with headroom
   localparam int ROT_W  = 34;   // cosine CORDIC x/y in Q30
   localparam int VEC_W  = 53;   // atan2 CORDIC x/y
   localparam int DLON_W = 33;   // longitude difference magnitude
   localparam int DY_W   = 48;   // latitude difference scaled by 2^16
   localparam int COS_W  = 31;   // clamped cosine, 0 .. 2^30
   localparam int MAG_W  = 50;   // |dx| after the cosine product
   localparam int ATAN_W = 30;

   // Constants
   localparam logic signed [ROT_W-1:0] GAIN_Q30     = 34'sd652032874;
   localparam logic signed [ROT_W-1:0] COS_ONE      = 34'sd1073741824;
   localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [ANG_W-1:0] HALF_TURN    = 34'sd2147483648;
   localparam logic [BEAR_W-1:0]       FULL_CIRCLE  = 25'd23592960;
   localparam logic [15:0]             DEG_TURN_LO  = 16'hC16C;    // low part of 6108397932
   localparam logic [16:0]             DEG_TURN_HI  = 17'h16C16;   // high part
   localparam int                      DEG_FULL     = 360;
   localparam int                      DEG_HALF     = 180;
   localparam int                      DEG_QUARTER  = 90;

   // atan(2^-i) as binary angles
   localparam logic [ATAN_W-1:0] ATAN_TABLE [32] = '{
      30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
      30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
      30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
      30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
      30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
      30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001,
      30'h00000001, 30'h00000000
   };

endpackage

// ----- sv/bbp_rot_cell.sv -----
// One rotation-mode CORDIC stage for the cosine of the start latitude.
// Depends on bbp_pkg for widths and the arctangent table.
`timescale 1ns / 1ps

module bbp_rot_cell #(
   parameter int STAGE  = 0,
   parameter int SIDE_W = 1
) (
   input  logic                              clock,
   input  logic                              enable,
   input  logic signed [bbp_pkg::ROT_W-1:0]  x_i,
   input  logic signed [bbp_pkg::ROT_W-1:0]  y_i,
   input  logic signed [bbp_pkg::ANG_W-1:0]  z_i,
   input  logic        [SIDE_W-1:0]          side_i,
   output logic signed [bbp_pkg::ROT_W-1:0]  x_o,
   output logic signed [bbp_pkg::ROT_W-1:0]  y_o,
   output logic signed [bbp_pkg::ANG_W-1:0]  z_o,
   output logic        [SIDE_W-1:0]          side_o
);

   localparam logic signed [bbp_pkg::ANG_W-1:0] ATAN =
      bbp_pkg::ANG_W'(bbp_pkg::ATAN_TABLE[STAGE]);

   logic signed [bbp_pkg::ROT_W-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [bbp_pkg::ANG_W-1:0] z_ff, z_in;
   logic        [SIDE_W-1:0]         side_ff;

   // rotate toward zero residual angle
   always_comb begin
      if (!z_i[bbp_pkg::ANG_W-1]) begin
         x_in = x_i - (y_i >>> STAGE);
         y_in = y_i + (x_i >>> STAGE);
         z_in = z_i - ATAN;
      end else begin
         x_in = x_i + (y_i >>> STAGE);
         y_in = y_i - (x_i >>> STAGE);
         z_in = z_i + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= side_i;
      end
   end

   assign x_o    = x_ff;
   assign y_o    = y_ff;
   assign z_o    = z_ff;
   assign side_o = side_ff;

endmodule

// ----- sv/bbp_vec_cell.sv -----
// One vectoring-mode CORDIC stage for atan2(dy, dx).
// Depends on bbp_pkg for widths and the arctangent table.
`timescale 1ns / 1ps

module bbp_vec_cell #(
   parameter int STAGE  = 0,
   parameter int SIDE_W = 1
) (
   input  logic                              clock,
   input  logic                              enable,
   input  logic signed [bbp_pkg::VEC_W-1:0]  x_i,
   input  logic signed [bbp_pkg::VEC_W-1:0]  y_i,
   input  logic signed [bbp_pkg::ANG_W-1:0]  z_i,
   input  logic        [SIDE_W-1:0]          side_i,
   output logic signed [bbp_pkg::VEC_W-1:0]  x_o,
   output logic signed [bbp_pkg::VEC_W-1:0]  y_o,
   output logic signed [bbp_pkg::ANG_W-1:0]  z_o,
   output logic        [SIDE_W-1:0]          side_o
);

   localparam logic signed [bbp_pkg::ANG_W-1:0] ATAN =
      bbp_pkg::ANG_W'(bbp_pkg::ATAN_TABLE[STAGE]);

   logic signed [bbp_pkg::VEC_W-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [bbp_pkg::ANG_W-1:0] z_ff, z_in;
   logic        [SIDE_W-1:0]         side_ff;

   // drive y toward zero, accumulate the angle
   always_comb begin
      if (!y_i[bbp_pkg::VEC_W-1]) begin
         x_in = x_i + (y_i >>> STAGE);
         y_in = y_i - (x_i >>> STAGE);
         z_in = z_i + ATAN;
      end else begin
         x_in = x_i - (y_i >>> STAGE);
         y_in = y_i + (x_i >>> STAGE);
         z_in = z_i - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= side_i;
      end
   end

   assign x_o    = x_ff;
   assign y_o    = y_ff;
   assign z_o    = z_ff;
   assign side_o = side_ff;

endmodule

// ----- sv/bearing_between_positions_top.sv -----
// Top level: equirectangular bearing pipeline with output skid stage.
// Depends on bbp_pkg, bbp_rot_cell and bbp_vec_cell.
`timescale 1ns / 1ps
//
//  channel | direction | handshake         | payload
//  req_    | in        | req_valid/stall   | from/to latitude, from/to longitude
//  rsp_    | out       | rsp_valid/stall   | bearing (degrees * 2^16)
//
// One position pair per cycle while not stalled; each result passes through the
// two chains of CORDIC cells (cosine, then atan2) plus setup and output stages.
// Reset (synchronous, active high) clears all valid bits and the skid stage.
// A stalled result moves into a one-entry skid; the pipeline freezes only when
// the skid is full, so req_stall is a register and never follows rsp_stall.

module bearing_between_positions_top #(
   parameter int CORDIC_STAGES   = 24,
   parameter int COORD_FRAC_BITS = 23
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [bbp_pkg::LAT_W-1:0]    req_from_latitude,
   input  logic signed [bbp_pkg::LON_W-1:0]    req_from_longitude,
   input  logic signed [bbp_pkg::LAT_W-1:0]    req_to_latitude,
   input  logic signed [bbp_pkg::LON_W-1:0]    req_to_longitude,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [bbp_pkg::BEAR_W-1:0]   rsp_bearing
);

   localparam int SH     = 23 - COORD_FRAC_BITS;
   localparam int A23_W  = 33 + SH;
   localparam int P_W    = A23_W + 18;
   localparam int ZS_W   = P_W + 17;
   localparam int NST    = 8 + 2 * CORDIC_STAGES;
   localparam int RSIDE_W = 1 + bbp_pkg::DLON_W + bbp_pkg::DY_W;
   localparam logic signed [32:0] NINETY  = 33'(bbp_pkg::DEG_QUARTER * 2**COORD_FRAC_BITS);
   localparam logic signed [32:0] HALF180 = 33'(bbp_pkg::DEG_HALF * 2**COORD_FRAC_BITS);

   // pipeline control
   logic [NST-1:0] v_ff, v_in;
   logic           pipe_en;
   logic           skid_full_ff, skid_full_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [bbp_pkg::BEAR_W-1:0] rsp_bearing_ff, rsp_bearing_in, skid_ff, skid_in;

   assign pipe_en   = !skid_full_ff;
   assign req_stall = skid_full_ff;

   // ---------------- stage 1: fold latitude, differences ----------------
   logic signed [31:0]              lat1_x, lat_abs, dlat;
   logic signed [32:0]              afold, dlon;
   logic                            fold;
   logic signed [A23_W-1:0]         a23_ff, a23_in;
   logic                            neg1_ff, neg1_in;
   logic [bbp_pkg::DLON_W-1:0]      dlon1_ff, dlon1_in;
   logic signed [bbp_pkg::DY_W-1:0] dy1_ff, dy1_in;

   always_comb begin
      lat1_x  = 32'(req_from_latitude);
      lat_abs = lat1_x[31] ? -lat1_x : lat1_x;
      fold    = 33'(lat_abs) > NINETY;
      afold   = fold ? (HALF180 - 33'(lat_abs)) : 33'(lat_abs);
      a23_in  = A23_W'(afold) <<< SH;
      dlon    = 33'(req_to_longitude) - 33'(req_from_longitude);
      neg1_in = fold ^ dlon[32];
      dlon1_in = dlon[32] ? bbp_pkg::DLON_W'(-dlon) : bbp_pkg::DLON_W'(dlon);
      dlat    = 32'(req_to_latitude) - 32'(req_from_latitude);
      dy1_in  = {dlat, 16'b0};
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a23_ff   <= a23_in;
         neg1_ff  <= neg1_in;
         dlon1_ff <= dlon1_in;
         dy1_ff   <= dy1_in;
      end
   end

   // ---------------- stage 2: partial products of degrees-to-turns -------
   logic signed [P_W-1:0]   plo_ff, phi_ff;
   logic [RSIDE_W-1:0]      side2_ff, side3_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         plo_ff   <= P_W'(a23_ff) * P_W'($signed({2'b00, bbp_pkg::DEG_TURN_LO}));
         phi_ff   <= P_W'(a23_ff) * P_W'($signed({1'b0, bbp_pkg::DEG_TURN_HI}));
         side2_ff <= {neg1_ff, dlon1_ff, dy1_ff};
      end
   end

   // ---------------- stage 3: round to binary angle ----------------------
   logic signed [ZS_W-1:0]          zsum;
   logic signed [bbp_pkg::ANG_W-1:0] z0_ff;

   assign zsum = (ZS_W'(phi_ff) <<< 16) + ZS_W'(plo_ff) + (ZS_W'(1) <<< 31);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         z0_ff    <= $signed({2'b00, zsum[63:32]});
         side3_ff <= side2_ff;
      end
   end

   // ---------------- cosine CORDIC chain ---------------------------------
   logic signed [bbp_pkg::ROT_W-1:0] rx [CORDIC_STAGES+1];
   logic signed [bbp_pkg::ROT_W-1:0] ry [CORDIC_STAGES+1];
   logic signed [bbp_pkg::ANG_W-1:0] rz [CORDIC_STAGES+1];
   logic        [RSIDE_W-1:0]        rs [CORDIC_STAGES+1];

   assign rx[0] = bbp_pkg::GAIN_Q30;
   assign ry[0] = '0;
   assign rz[0] = z0_ff;
   assign rs[0] = side3_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
      bbp_rot_cell #(.STAGE(g), .SIDE_W(RSIDE_W)) u_cell (
         .clock  (clock),
         .enable (pipe_en),
         .x_i    (rx[g]),
         .y_i    (ry[g]),
         .z_i    (rz[g]),
         .side_i (rs[g]),
         .x_o    (rx[g+1]),
         .y_o    (ry[g+1]),
         .z_o    (rz[g+1]),
         .side_o (rs[g+1])
      );
   end

   // ---------------- clamp cosine ----------------------------------------
   logic signed [bbp_pkg::ROT_W-1:0] xc;
   logic [bbp_pkg::COS_W-1:0]        cos_ff;
   logic [RSIDE_W-1:0]               side4_ff;

   always_comb begin
      xc = rx[CORDIC_STAGES];
      if (xc[bbp_pkg::ROT_W-1]) begin
         xc = '0;
      end else if (xc > bbp_pkg::COS_ONE) begin
         xc = bbp_pkg::COS_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         cos_ff   <= bbp_pkg::COS_W'(xc);
         side4_ff <= rs[CORDIC_STAGES];
      end
   end

   // ---------------- dx magnitude ----------------------------------------
   logic [63:0]                      mprod;
   logic [bbp_pkg::MAG_W-1:0]        mag_ff;
   logic                             neg5_ff;
   logic signed [bbp_pkg::DY_W-1:0]  dy5_ff;

   assign mprod = 64'(cos_ff) * 64'(side4_ff[bbp_pkg::DY_W +: bbp_pkg::DLON_W]);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         mag_ff  <= mprod[14 +: bbp_pkg::MAG_W];
         neg5_ff <= side4_ff[RSIDE_W-1];
         dy5_ff  <= side4_ff[bbp_pkg::DY_W-1:0];
      end
   end

   // ---------------- atan2 setup: half-plane fold, zero case -------------
   logic signed [bbp_pkg::VEC_W-1:0] dx6, dy6;
   logic signed [bbp_pkg::VEC_W-1:0] vx0_ff, vy0_ff;
   logic signed [bbp_pkg::ANG_W-1:0] vz0_ff;
   logic                             zero6_ff;

   always_comb begin
      dx6 = neg5_ff ? -bbp_pkg::VEC_W'(mag_ff) : bbp_pkg::VEC_W'(mag_ff);
      dy6 = bbp_pkg::VEC_W'(dy5_ff);
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         zero6_ff <= (dx6 == '0) && (dy6 == '0);
         if (dx6[bbp_pkg::VEC_W-1]) begin
            vx0_ff <= -dx6;
            vy0_ff <= -dy6;
            vz0_ff <= dy6[bbp_pkg::VEC_W-1] ? -bbp_pkg::HALF_TURN : bbp_pkg::HALF_TURN;
         end else begin
            vx0_ff <= dx6;
            vy0_ff <= dy6;
            vz0_ff <= '0;
         end
      end
   end

   // ---------------- atan2 CORDIC chain ----------------------------------
   logic signed [bbp_pkg::VEC_W-1:0] vx [CORDIC_STAGES+1];
   logic signed [bbp_pkg::VEC_W-1:0] vy [CORDIC_STAGES+1];
   logic signed [bbp_pkg::ANG_W-1:0] vz [CORDIC_STAGES+1];
   logic        [0:0]                vs [CORDIC_STAGES+1];

   assign vx[0] = vx0_ff;
   assign vy[0] = vy0_ff;
   assign vz[0] = vz0_ff;
   assign vs[0] = zero6_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
      bbp_vec_cell #(.STAGE(g), .SIDE_W(1)) u_cell (
         .clock  (clock),
         .enable (pipe_en),
         .x_i    (vx[g]),
         .y_i    (vy[g]),
         .z_i    (vz[g]),
         .side_i (vs[g]),
         .x_o    (vx[g+1]),
         .y_o    (vy[g+1]),
         .z_o    (vz[g+1]),
         .side_o (vs[g+1])
      );
   end

   // ---------------- compass angle times 360 -----------------------------
   logic signed [bbp_pkg::ANG_W-1:0] ang7, diff7;
   logic [40:0]                      p360_ff;

   always_comb begin
      ang7  = vs[CORDIC_STAGES][0] ? '0 : vz[CORDIC_STAGES];
      diff7 = bbp_pkg::QUARTER_TURN - ang7;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         p360_ff <= 41'(diff7[31:0]) * 41'(bbp_pkg::DEG_FULL);
      end
   end

   // ---------------- round to 16 fraction bits, zero maps to full circle --
   logic [40:0]                round8;
   logic [bbp_pkg::BEAR_W-1:0] bear8_ff, bear8_in;

   always_comb begin
      round8   = p360_ff + 41'd32768;
      bear8_in = round8[16 +: bbp_pkg::BEAR_W];
      if (bear8_in == '0) begin
         bear8_in = bbp_pkg::FULL_CIRCLE;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         bear8_ff <= bear8_in;
      end
   end

   // ---------------- valid bits --------------------------------------------
   assign v_in = {v_ff[NST-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (pipe_en) begin
         v_ff <= v_in;
      end
   end

   // ---------------- output register and skid ----------------------------
   logic take;
   assign take = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_bearing_in = rsp_bearing_ff;
      skid_full_in   = skid_full_ff;
      skid_in        = skid_ff;
      if (skid_full_ff) begin
         if (take) begin
            rsp_bearing_in = skid_ff;
            skid_full_in   = 1'b0;
         end
      end else if (!rsp_valid_ff || take) begin
         rsp_valid_in   = v_ff[NST-1];
         rsp_bearing_in = bear8_ff;
      end else if (v_ff[NST-1]) begin
         skid_in      = bear8_ff;
         skid_full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_full_ff <= skid_full_in;
      end
      rsp_bearing_ff <= rsp_bearing_in;
      skid_ff        <= skid_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_bearing = rsp_bearing_ff;

   // ---------------- assertions --------------------------------------------
   a_skid_has_out: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> rsp_valid_ff)
      else $error("skid holds a result while output register is empty");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff && rsp_stall |=> skid_full_ff && rsp_valid_ff)
      else $error("skid drained while output stalled");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(v_ff))
      else $error("pipeline moved while frozen");

   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_bearing_ff != '0)
      else $error("bearing of zero presented");

endmodule

// ----- tb/bearing_between_positions_top_tb.sv -----
// Self-checking testbench for bearing_between_positions_top: randomized valid/stall traffic.
// Depends on bbp_pkg and the RTL; predicts every bearing with its own fixed-point CORDIC.
`timescale 1ns / 1ps

module bearing_between_positions_top_tb;

   localparam int STAGES    = 24;
   localparam int FRAC      = 23;
   localparam int IDLE_MAX  = 5000;
   localparam longint LAT90 = 64'd90 << FRAC;
   localparam longint LON180 = 64'd180 << FRAC;
   localparam longint ATAN_ROM [32] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
      'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
      'h00000001, 'h00000000};

   typedef struct {
      logic signed [bbp_pkg::LAT_W-1:0] from_lat;
      logic signed [bbp_pkg::LON_W-1:0] from_lon;
      logic signed [bbp_pkg::LAT_W-1:0] to_lat;
      logic signed [bbp_pkg::LON_W-1:0] to_lon;
      bit                               drain_first;   // wait for all results before this one
   } position_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [bbp_pkg::LAT_W-1:0] req_from_latitude = '0;
   logic signed [bbp_pkg::LON_W-1:0] req_from_longitude = '0;
   logic signed [bbp_pkg::LAT_W-1:0] req_to_latitude = '0;
   logic signed [bbp_pkg::LON_W-1:0] req_to_longitude = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [bbp_pkg::BEAR_W-1:0] rsp_bearing;

   position_pair_type          pair_queue[$];
   logic [bbp_pkg::BEAR_W-1:0] bearing_due[$];
   int  mismatches = 0;
   int  idle_cycles = 0;
   bit  req_took = 1'b0;
   int  burst_left = 4;
   int  gap_left = 0;
   int  stall_mode = 0;
   int  stall_left = 0;
   int  mode_cycles = 0;

   bearing_between_positions_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_from_latitude(req_from_latitude), .req_from_longitude(req_from_longitude),
      .req_to_latitude(req_to_latitude), .req_to_longitude(req_to_longitude),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_bearing(rsp_bearing)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Cosine magnitude in Q30 of a latitude magnitude within [0,90] degrees
   function automatic longint cosine_q30(longint unsigned alat);
      longint unsigned prod;
      longint x, y, z, xs, ys;
      prod = alat * 64'd6108397932 + 64'd2147483648;
      z = longint'(prod >> 32);
      x = 652032874;
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
         xs = x >>> (i % 32);
         ys = y >>> (i % 32);
         if (z >= 0) begin
            x -= ys; y += xs; z -= ATAN_ROM[i % 32];
         end else begin
            x += ys; y -= xs; z += ATAN_ROM[i % 32];
         end
      end
      if (x < 0) x = 0;
      if (x > 64'sd1073741824) x = 64'sd1073741824;
      return x;
   endfunction

   // atan2 as a binary angle, 2^32 per turn
   function automatic longint angle_turns(longint y, longint x);
      longint z, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STAGES; i++) begin
         xs = x >>> (i % 32);
         ys = y >>> (i % 32);
         if (y >= 0) begin
            x += ys; y -= xs; z += ATAN_ROM[i % 32];
         end else begin
            x -= ys; y += xs; z -= ATAN_ROM[i % 32];
         end
      end
      return z;
   endfunction

   function automatic logic [bbp_pkg::BEAR_W-1:0] compass_bearing(position_pair_type p);
      longint lat1, lat2, lon1, lon2, c, dlon, dx, dy, ang;
      longint unsigned alat, mag, u, b;
      bit flip;
      lat1 = p.from_lat; lat2 = p.to_lat;
      lon1 = p.from_lon; lon2 = p.to_lon;
      flip = 1'b0;
      alat = (lat1 < 0) ? -lat1 : lat1;
      // latitude past a pole folds the cosine sign
      if (alat > LAT90) begin
         alat = LON180 - alat;
         flip = 1'b1;
      end
      c = cosine_q30(alat);
      dlon = lon2 - lon1;
      if (dlon < 0) begin
         flip = !flip;
         dlon = -dlon;
      end
      mag = (longint'(c) * longint'(dlon)) >> 14;
      dx = flip ? -longint'(mag) : longint'(mag);
      dy = (lat2 - lat1) * 65536;
      ang = angle_turns(dy, dx);
      u = (64'd1073741824 - ang) & 64'hFFFFFFFF;
      b = (u * 360 + 32768) >> 16;
      if (b == 0) b = 23592960;
      return b[bbp_pkg::BEAR_W-1:0];
   endfunction

   function automatic position_pair_type make_pair(longint fla, longint flo, longint tla,
                                                   longint tlo);
      position_pair_type p;
      p.from_lat = fla[bbp_pkg::LAT_W-1:0];
      p.from_lon = flo[bbp_pkg::LON_W-1:0];
      p.to_lat   = tla[bbp_pkg::LAT_W-1:0];
      p.to_lon   = tlo[bbp_pkg::LON_W-1:0];
      p.drain_first = 1'b0;
      return p;
   endfunction

   function automatic longint rand_lat();
      return longint'($urandom_range(0, 1509949440)) - 754974720;
   endfunction

   function automatic longint rand_lon();
      return longint'($urandom_range(0, 32'd3019898880)) - 1509949440;
   endfunction

   // Sender: bursts with random gaps; a stalled transfer holds its payload
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_took)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pair_queue.size() != 0 &&
                      !(pair_queue[0].drain_first && bearing_due.size() != 0)) begin
            position_pair_type p;
            p = pair_queue.pop_front();
            req_from_latitude  <= p.from_lat;
            req_from_longitude <= p.from_lon;
            req_to_latitude    <= p.to_lat;
            req_to_longitude   <= p.to_lon;
            req_valid <= 1'b1;
            if (--burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern: none, random, or long runs, switching every so often
   always @(negedge clock) begin
      if (mode_cycles == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_cycles = $urandom_range(20, 150);
      end
      mode_cycles--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 1) == 1);
         default: begin
            if (stall_left == 0) stall_left = $urandom_range(1, 40);
            stall_left--;
            rsp_stall <= (stall_left > 10);
         end
      endcase
   end

   // Monitor: predict on each accepted request, check each accepted result
   always @(posedge clock) begin
      req_took = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            position_pair_type p;
            p = make_pair(req_from_latitude, req_from_longitude, req_to_latitude,
                          req_to_longitude);
            bearing_due.push_back(compass_bearing(p));
            req_took = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (bearing_due.size() == 0) begin
               $error("unexpected result: bearing %0d", rsp_bearing);
               mismatches++;
            end else begin
               logic [bbp_pkg::BEAR_W-1:0] want;
               want = bearing_due.pop_front();
               if (rsp_bearing !== want) begin
                  $error("bearing mismatch: expected %0d actual %0d", want, rsp_bearing);
                  mismatches++;
               end
            end
         end
         // watchdog on transfer-free cycles
         if (req_took || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_MAX) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      position_pair_type p;
      longint a, b;
      // coincident, cardinal directions, field and range extremes
      pair_queue.push_back(make_pair(0, 0, 0, 0));
      pair_queue.push_back(make_pair(0, 0, 8388608, 0));
      pair_queue.push_back(make_pair(0, 0, -8388608, 0));
      pair_queue.push_back(make_pair(0, 0, 0, 8388608));
      pair_queue.push_back(make_pair(0, 0, 0, -8388608));
      pair_queue.push_back(make_pair(754974720, 0, -754974720, 1509949440));
      pair_queue.push_back(make_pair(-754974720, 1509949440, 754974720, -1509949440));
      pair_queue.push_back(make_pair(754974720, 5, 754974720, -5));
      pair_queue.push_back(make_pair(-1073741824, -2147483648, 1073741823, 2147483647));
      pair_queue.push_back(make_pair(1073741823, 2147483647, -1073741824, -2147483648));
      pair_queue.push_back(make_pair(1000000000, 0, 1000000000, 1000));
      pair_queue.push_back(make_pair(-1000000000, 1000, -999999999, 0));
      pair_queue.push_back(make_pair(100, 100, 100, 100));
      pair_queue.push_back(make_pair(0, 0, 1, 1));
      pair_queue.push_back(make_pair(0, 0, -1, -1));
      pair_queue.push_back(make_pair(0, 0, 1, 0));
      pair_queue.push_back(make_pair(0, 0, -1, 1000000));
      pair_queue.push_back(make_pair(419430400, -12345678, 419430400, 12345678));
      pair_queue.push_back(make_pair(-1073741824, 0, -1073741824, 0));
      pair_queue.push_back(make_pair(0, -2147483648, 0, 2147483647));
      for (int n = 0; n < 1200; n++) begin
         case ($urandom_range(0, 9))
            7: p = make_pair(int'($urandom), int'($urandom), int'($urandom), int'($urandom));
            8: begin
               a = rand_lat(); b = rand_lon();
               p = make_pair(a, b, a + $urandom_range(0, 200) - 100,
                             b + $urandom_range(0, 200) - 100);
            end
            9: begin
               a = rand_lat(); b = rand_lon();
               case ($urandom_range(0, 2))
                  0: p = make_pair(a, b, a, b);
                  1: p = make_pair(a, b, rand_lat(), b);
                  default: p = make_pair(a, b, a, rand_lon());
               endcase
            end
            default: p = make_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
         endcase
         p.drain_first = (n == 600);
         pair_queue.push_back(p);
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (pair_queue.size() != 0 || req_valid || bearing_due.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0 && bearing_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
